// ===== sv/mtwg_pkg.sv =====
// shared types, constants and word functions of the mersenne twister word generator
package mtwg_pkg;

  typedef logic [31:0] word_t;
  typedef logic [9:0]  addr_t;
  typedef logic [15:0] half_t;

  localparam int    StateWordsInt = 624;
  localparam int    TapOffsetInt  = 397;

  localparam addr_t STATE_WORDS = addr_t'(StateWordsInt);
  localparam addr_t LAST_WORD   = addr_t'(StateWordsInt - 1);
  localparam addr_t TAP_OFFSET  = addr_t'(TapOffsetInt);
  localparam addr_t TAP_WRAP    = addr_t'(StateWordsInt - TapOffsetInt);
  localparam addr_t UNSEEDED    = addr_t'(StateWordsInt + 1);

  localparam word_t TWIST_MATRIX = 32'h9908_b0df;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;
  localparam word_t LCG_MULT     = 32'd69069;
  localparam word_t SEED_DEFAULT = 32'd4357;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL_HI,
    ST_FILL_LO,
    ST_TW_PRIME,
    ST_TW_FIRST,
    ST_TWIST
  } state_t;

  function automatic word_t lcg_step(input word_t s);
    return s * LCG_MULT + 32'd1;
  endfunction

  function automatic addr_t next_of(input addr_t k);
    return (k == LAST_WORD) ? '0 : k + 10'd1;
  endfunction

  function automatic addr_t tap_of(input addr_t k);
    return (k >= TAP_WRAP) ? k - TAP_WRAP : k + TAP_OFFSET;
  endfunction

  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t tap);
    word_t y;
    word_t v;
    y = {cur[31], nxt[30:0]};
    v = tap ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== sv/mtwg_out.sv =====
// tempering and output register of the result channel
module mtwg_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  mtwg_pkg::word_t raw_word,
  output logic           free,
  output mtwg_pkg::word_t random_word,
  output logic           rsp_valid,
  input  logic           rsp_stall
);
  import mtwg_pkg::*;

  assign free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      random_word <= temper(raw_word);
    end
  end

  // a new word may only enter when the held one is gone or leaving
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("output register overwritten while stalled");

endmodule

// ===== sv/mersenne_twister_word_generator_unit.sv =====
// mersenne twister word generator: state memory, seed fill, state loads, twist and draw sequencer
//
//  channel | signals                               | direction
//  req     | req_valid req_stall req_type load_word | in, item accepted when valid and !stall
//  rsp     | rsp_valid rsp_stall random_word        | out, one item per draw
//  cfg     | cfg_valid cfg_ready seed_value         | in, seed write
//
//  a load is written as it is accepted; a draw registers its word, then waits on rsp_stall
//  a draw that finds the state spent first twists it, one word per cycle
//  (two read ports and one write port of the state memory)
//  a draw after a seed write fills the state (two lcg steps per word) before the twist
//  reset clears control only; the state memory holds nothing until filled or loaded
//  req_stall is high while a draw, fill or twist is under way and while a seed write is offered
module mersenne_twister_word_generator_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  logic            req_type,
  input  mtwg_pkg::word_t load_word,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mtwg_pkg::word_t random_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  mtwg_pkg::word_t seed_value
);
  import mtwg_pkg::*;

  word_t  mem [StateWordsInt];
  word_t  rd_a;
  word_t  rd_b;

  state_t state;
  state_t state_next;
  addr_t  word_index;
  addr_t  word_index_next;
  addr_t  load_pointer;
  addr_t  load_pointer_next;
  addr_t  k;
  addr_t  k_next;
  word_t  seed_reg;
  word_t  lcg;
  word_t  lcg_next;
  half_t  hi;
  half_t  hi_next;
  word_t  cur;
  word_t  cur_next;

  logic   mem_we;
  addr_t  wr_addr;
  word_t  wr_data;
  logic   rd_en_a;
  addr_t  rd_addr_a;
  logic   rd_en_b;
  addr_t  rd_addr_b;
  logic   out_load;
  logic   out_free;
  logic   req_acc;
  logic   cfg_acc;
  addr_t  k_plus1;

  // a seed write goes first, the request waits while cfg_valid is high
  assign req_stall = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign k_plus1   = k + 10'd1;

  // state memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      word_index   <= UNSEEDED;
      load_pointer <= '0;
      seed_reg     <= SEED_DEFAULT;
      k            <= '0;
    end else begin
      state        <= state_next;
      word_index   <= word_index_next;
      load_pointer <= load_pointer_next;
      k            <= k_next;
      if (cfg_acc) begin
        seed_reg <= seed_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    lcg <= lcg_next;
    hi  <= hi_next;
    cur <= cur_next;
  end

  always_comb begin
    state_next        = state;
    word_index_next   = word_index;
    load_pointer_next = load_pointer;
    k_next            = k;
    lcg_next          = lcg;
    hi_next           = hi;
    cur_next          = cur;
    mem_we            = 1'b0;
    wr_addr           = k;
    wr_data           = twist_word(cur, rd_a, rd_b);
    rd_en_a           = 1'b0;
    rd_addr_a         = '0;
    rd_en_b           = 1'b0;
    rd_addr_b         = '0;
    out_load          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cfg_acc) begin
          word_index_next = UNSEEDED;
        end else if (req_acc) begin
          if (req_type == REQ_LOAD) begin
            mem_we  = 1'b1;
            wr_addr = load_pointer;
            wr_data = load_word;
            if (load_pointer == LAST_WORD) begin
              load_pointer_next = '0;
              word_index_next   = STATE_WORDS;
            end else begin
              load_pointer_next = load_pointer + 10'd1;
            end
          end else begin
            priority if (word_index == UNSEEDED) begin
              lcg_next   = seed_reg;
              k_next     = '0;
              state_next = ST_FILL_HI;
            end else if (word_index == STATE_WORDS) begin
              state_next = ST_TW_PRIME;
            end else begin
              rd_en_a         = 1'b1;
              rd_addr_a       = word_index;
              word_index_next = word_index + 10'd1;
              state_next      = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FILL_HI: begin
        hi_next    = lcg[31:16];
        lcg_next   = lcg_step(lcg);
        state_next = ST_FILL_LO;
      end
      ST_FILL_LO: begin
        mem_we   = 1'b1;
        wr_addr  = k;
        wr_data  = {hi, lcg[31:16]};
        lcg_next = lcg_step(lcg);
        if (k == LAST_WORD) begin
          state_next = ST_TW_PRIME;
        end else begin
          k_next     = k_plus1;
          state_next = ST_FILL_HI;
        end
      end
      ST_TW_PRIME: begin
        rd_en_a    = 1'b1;
        rd_addr_a  = '0;
        k_next     = '0;
        state_next = ST_TW_FIRST;
      end
      ST_TW_FIRST: begin
        cur_next   = rd_a;
        rd_en_a    = 1'b1;
        rd_addr_a  = next_of(k);
        rd_en_b    = 1'b1;
        rd_addr_b  = tap_of(k);
        state_next = ST_TWIST;
      end
      ST_TWIST: begin
        // rd_a holds word k+1, rd_b the tap word, both already twisted where due
        mem_we   = 1'b1;
        wr_addr  = k;
        wr_data  = twist_word(cur, rd_a, rd_b);
        cur_next = rd_a;
        if (k == LAST_WORD) begin
          rd_en_a         = 1'b1;
          rd_addr_a       = '0;
          word_index_next = 10'd1;
          state_next      = ST_READ;
        end else begin
          rd_en_a   = 1'b1;
          rd_addr_a = next_of(k_plus1);
          rd_en_b   = 1'b1;
          rd_addr_b = tap_of(k_plus1);
          k_next    = k_plus1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  mtwg_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (out_load),
    .raw_word    (rd_a),
    .free        (out_free),
    .random_word (random_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    word_index <= UNSEEDED && load_pointer <= LAST_WORD)
    else $error("word index or load pointer out of range");

  // the twist must never read the entry it is writing
  a_twist_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWIST && rd_en_b) |-> (wr_addr != rd_addr_a && wr_addr != rd_addr_b))
    else $error("twist read and write collide");

  a_idle_write_is_load: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_IDLE) |-> (req_acc && req_type == REQ_LOAD))
    else $error("state memory written while idle without a load");

  a_twist_ends_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWIST && k == LAST_WORD) |=> (state == ST_READ && word_index == 10'd1))
    else $error("twist did not hand over to the draw of word zero");

endmodule

// ===== tb/mersenne_twister_word_generator_unit_tb.sv =====
// testbench for the mersenne twister word generator: seeding, loads, draws and twists
`timescale 1ns / 1ps

module mersenne_twister_word_generator_unit_tb;
  import mtwg_pkg::*;

  localparam int    CYCLE_LIMIT  = 600000;
  localparam int    HOLD_CYCLES  = 400;
  localparam int    IDLE_SETTLE  = 6;
  localparam int    DRAIN_CYCLES = 20;
  localparam word_t HALF_MASK    = 32'hffff_0000;
  localparam word_t TOP_BIT      = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7fff_ffff;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  logic  req_type;
  word_t load_word;
  logic  rsp_valid;
  logic  rsp_stall;
  word_t random_word;
  logic  cfg_valid;
  logic  cfg_ready;
  word_t seed_value;

  // generator state as the testbench sees it
  word_t gen_words [StateWordsInt];
  addr_t gen_index;
  addr_t gen_load_ptr;
  word_t gen_seed;

  word_t expected_words [$];

  int mismatch_count;
  int cycle_count;
  int burst_left;
  int draws_sent;
  int loads_sent;
  int seeds_written;
  int twists_seen;
  int words_checked;

  logic hold_request;
  int   hold_left;
  int   span_left;
  int   stall_mode;

  mersenne_twister_word_generator_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .load_word  (load_word),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .random_word(random_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .seed_value (seed_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d words outstanding", cycle_count,
               expected_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("ERROR cycle %0d: %s: got %08h want %08h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void fill_words_from_seed();
    word_t s;
    word_t w;
    s = gen_seed;
    for (int k = 0; k < StateWordsInt; k++) begin
      w = s & HALF_MASK;
      s = s * LCG_MULT + 32'd1;
      w = w | ((s & HALF_MASK) >> 16);
      s = s * LCG_MULT + 32'd1;
      gen_words[k] = w;
    end
  endfunction

  // in place, so the wrapped taps see words already twisted
  function automatic void twist_words();
    word_t y;
    word_t v;
    for (int k = 0; k < StateWordsInt; k++) begin
      y = (gen_words[k] & TOP_BIT) | (gen_words[(k + 1) % StateWordsInt] & LOW_BITS);
      v = gen_words[(k + TapOffsetInt) % StateWordsInt] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TWIST_MATRIX;
      end
      gen_words[k] = v;
    end
  endfunction

  function automatic word_t draw_word();
    word_t y;
    if (gen_index >= STATE_WORDS) begin
      if (gen_index == UNSEEDED) begin
        fill_words_from_seed();
      end
      twist_words();
      twists_seen++;
      gen_index = '0;
    end
    y = gen_words[gen_index];
    gen_index = gen_index + 10'd1;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void store_load_word(input word_t w);
    addr_t p;
    p = (gen_load_ptr < STATE_WORDS) ? gen_load_ptr : '0;
    gen_words[p] = w;
    p = p + 10'd1;
    // last word loaded: pointer wraps and a twist is due
    if (p >= STATE_WORDS) begin
      p = '0;
      gen_index = STATE_WORDS;
    end
    gen_load_ptr = p;
  endfunction

  function automatic void apply_request(input logic kind, input word_t w);
    if (kind == REQ_LOAD) begin
      store_load_word(w);
      loads_sent++;
    end else begin
      expected_words.push_back(draw_word());
      draws_sent++;
    end
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(input logic kind, input word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
                                                 $urandom_range(1, 16);
    end
    burst_left--;
    req_valid <= 1'b1;
    req_type  <= kind;
    load_word <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_request(kind, w);
  endtask

  task automatic send_draws(input int count);
    for (int k = 0; k < count; k++) begin
      send_item(REQ_DRAW, $urandom);
    end
  endtask

  function automatic word_t random_state_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  // let everything drain so the block is idle
  task automatic quiesce();
    req_valid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input word_t s);
    quiesce();
    cfg_valid  <= 1'b1;
    seed_value <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gen_seed  = s;
    gen_index = UNSEEDED;
    seeds_written++;
  endtask

  // ---------------------------------------------------------------- receiving

  initial begin
    rsp_stall = 1'b0;
    hold_left = 0;
    span_left = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (span_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          span_left = $urandom_range(10, 80);
        end
        span_left--;
        case (stall_mode)
          0: begin
            rsp_stall <= 1'b0;
          end
          1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
          end
          default: begin
            rsp_stall <= (span_left % 3 == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_words
    word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with no draw pending", random_word, '0);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (random_word !== want) begin
          report_mismatch("random_word", random_word, want);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // first draws after reset fill from the default seed
  task automatic test_unseeded_draws();
    send_draws(3);
  endtask

  task automatic test_seed_extremes();
    write_seed('0);
    send_draws(2);
    write_seed('1);
    send_draws(2);
  endtask

  task automatic test_partial_load();
    // seeded: loaded words are read back by the following draws
    send_item(REQ_LOAD, '0);
    send_item(REQ_LOAD, '1);
    send_item(REQ_LOAD, 32'h8000_0000);
    send_item(REQ_LOAD, 32'h7fff_ffff);
    send_item(REQ_LOAD, 32'h5555_aaaa);
    send_draws(3);
    // unseeded: the fill overwrites what was loaded, pointer is kept
    write_seed(32'd12345);
    send_item(REQ_LOAD, 32'haaaa_5555);
    send_item(REQ_LOAD, '1);
    send_item(REQ_LOAD, 32'h0000_0001);
    send_draws(1);
  endtask

  // a load that runs to the last word after a seed write makes the next draw twist without a fill
  task automatic test_full_load();
    int n;
    write_seed(32'd1);
    n = StateWordsInt - int'(gen_load_ptr);
    send_item(REQ_LOAD, '1);
    for (int k = 1; k < n - 1; k++) begin
      send_item(REQ_LOAD, random_state_word());
    end
    send_item(REQ_LOAD, '0);
    send_draws(8);
  endtask

  task automatic test_backpressure();
    quiesce();
    hold_request = 1'b1;
    send_draws(40);
  endtask

  task automatic run_mixed_phase(input int items, input int draw_pct);
    int sent;
    int run;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(1, 100) <= draw_pct) begin
        run = $urandom_range(1, 40);
        for (int k = 0; k < run && sent < items; k++) begin
          send_item(REQ_DRAW, $urandom);
          sent++;
        end
      end else begin
        run = $urandom_range(1, 24);
        for (int k = 0; k < run && sent < items; k++) begin
          send_item(REQ_LOAD, random_state_word());
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    run_mixed_phase(320, 85);
    write_seed($urandom);
    run_mixed_phase(80, 50);
    send_draws($urandom_range(5, 20));
    write_seed($urandom);
    run_mixed_phase(60, 70);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_DRAW;
    load_word = '0;
    cfg_valid = 1'b0;
    seed_value = SEED_DEFAULT;
    hold_request = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    draws_sent = 0;
    loads_sent = 0;
    seeds_written = 0;
    twists_seen = 0;
    words_checked = 0;
    for (int k = 0; k < StateWordsInt; k++) begin
      gen_words[k] = '0;
    end
    gen_index = UNSEEDED;
    gen_load_ptr = '0;
    gen_seed = SEED_DEFAULT;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unseeded_draws();
    test_seed_extremes();
    test_partial_load();
    test_full_load();
    test_backpressure();
    test_random_traffic();

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d draws, %0d state loads, %0d seed writes, %0d twists",
             draws_sent, loads_sent, seeds_written, twists_seen);
    $display("%0d words checked in %0d cycles", words_checked, cycle_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
